// ===== rtl/noise_shaped_dither_requantizer_defines.svh =====
// Assertion macros for the noise-shaped dither requantizer.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef NOISE_SHAPED_DITHER_REQUANTIZER_DEFINES_SVH
`define NOISE_SHAPED_DITHER_REQUANTIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NSDR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked out of reset.
`define NSDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/nsdr_pkg.sv =====
// Shared types and constants for the noise-shaped dither requantizer.
// No dependencies; imported by nsdr_shaper and the top level.
package nsdr_pkg;

	localparam int IN_W    = 32;
	localparam int OUT_W   = 16;
	localparam int ERR_W   = 12;
	localparam int PRNG_W  = 32;
	localparam int FULL_W  = 24;
	localparam int SCALE_W = 8;
	localparam int SUM_W   = IN_W + 2;
	localparam int BIAS_W  = IN_W + 3;
	localparam int DITH_W  = SCALE_W + 2;

	typedef logic signed [IN_W-1:0]   sample_t;
	typedef logic signed [OUT_W-1:0]  result_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic        [PRNG_W-1:0] prng_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [BIAS_W-1:0] wide_t;
	typedef logic signed [DITH_W-1:0] dith_t;
	typedef logic signed [FULL_W-1:0] full_t;

	localparam prng_t LCG_MUL   = 32'd1664525;
	localparam prng_t LCG_ADD   = 32'd1013904223;
	localparam wide_t ROUND_ADD = 35'sd128;
	localparam wide_t FULL_MAX  = 35'sd8388607;
	localparam wide_t FULL_MIN  = -35'sd8388608;

endpackage

// ===== rtl/nsdr_shaper.sv =====
// Error-feedback requantizer datapath with the error history and dither generator state.
// Depends on nsdr_pkg; state advances once per item on the advance strobe.
module nsdr_shaper (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              input_is_32bit,
	input  nsdr_pkg::sample_t sample,
	output nsdr_pkg::result_t result
);
	import nsdr_pkg::*;

	err_t    e0_q, e1_q, e2_q;
	prng_t   prng_q, next_q;
	sample_t scaled;
	sum_t    s_sum;
	dith_t   dith;
	wide_t   o_sum, s_wide, s_lim;
	logic    clip_pos, clip_neg;
	full_t   o_clip, o_quant;
	wide_t   err_wide;
	err_t    e0_half;
	prng_t   lcg_prod;

	always_comb begin
		scaled = input_is_32bit ? (sample >>> SCALE_W) : sample;
		s_sum  = SUM_W'(scaled) + SUM_W'(e0_q) - SUM_W'(e1_q) + SUM_W'(e2_q);
		dith   = $signed({2'b00, next_q[SCALE_W-1:0]}) - $signed({2'b00, prng_q[SCALE_W-1:0]});
		s_wide = BIAS_W'(s_sum);
		o_sum  = s_wide + ROUND_ADD + BIAS_W'(dith);

		clip_pos = o_sum > FULL_MAX;
		clip_neg = o_sum < FULL_MIN;

		s_lim = s_wide;
		if (clip_pos && (s_wide > FULL_MAX)) begin
			s_lim = FULL_MAX;
		end else if (clip_neg && (s_wide < FULL_MIN)) begin
			s_lim = FULL_MIN;
		end

		if (clip_pos) begin
			o_clip = FULL_MAX[FULL_W-1:0];
		end else if (clip_neg) begin
			o_clip = FULL_MIN[FULL_W-1:0];
		end else begin
			o_clip = o_sum[FULL_W-1:0];
		end
		o_quant = {o_clip[FULL_W-1:SCALE_W], {SCALE_W{1'b0}}};

		err_wide = s_lim - BIAS_W'(o_quant);
		e0_half  = (e0_q + $signed(ERR_W'({e0_q[ERR_W-1]}))) >>> 1;
		lcg_prod = next_q * LCG_MUL;
	end

	assign result = o_clip[FULL_W-1:SCALE_W];

	// The generator runs one word ahead so that the multiplier feeds only a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_q   <= '0;
			e1_q   <= '0;
			e2_q   <= '0;
			prng_q <= '0;
			next_q <= LCG_ADD;
		end else if (advance) begin
			e0_q   <= err_wide[ERR_W-1:0];
			e1_q   <= e0_half;
			e2_q   <= e1_q;
			prng_q <= next_q;
			next_q <= lcg_prod + LCG_ADD;
		end
	end

endmodule

// ===== rtl/noise_shaped_dither_requantizer.sv =====
// Top level of the noise-shaped dither requantizer: input register, shaper, result register.
// Depends on nsdr_pkg, nsdr_shaper and noise_shaped_dither_requantizer_defines.svh.
//
// Usage:
// The in channel (in_valid, in_ready) carries one signed sample and a last flag per item.
// The out channel (out_valid, out_ready) returns one 16-bit sample per item, with last_out
// copied from last_in. The cfg channel (cfg_valid, cfg_ready, cfg_data) writes the mode
// bit: 1 means samples are 32-bit and are shifted right by eight before shaping. It is
// always ready and should be written only while no item is in flight.
// An accepted item is registered in the input register and then in the result register,
// where out_valid marks it. One item is accepted per cycle while the receiver does not
// stall; the rate is set by the error-feedback loop in the shaper, which updates the
// error history and the dither generator as each item moves into the result register.
// Reset clears the mode bit, the error history and the generator word, and empties both
// pipeline registers. When the receiver stalls, the result register holds its item and
// the input register holds one more; in_ready drops only when both are full.
`include "noise_shaped_dither_requantizer_defines.svh"

module noise_shaped_dither_requantizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  nsdr_pkg::sample_t in_sample,
	input  logic              last_in,
	output logic              out_valid,
	input  logic              out_ready,
	output nsdr_pkg::result_t out_sample,
	output logic              last_out
);
	import nsdr_pkg::*;

	logic    mode_q;
	logic    valid_s1, valid_s2;
	sample_t sample_s1;
	logic    last_s1, last_s2;
	result_t result_s2;
	result_t shaped;
	logic    adv;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_sample;
			last_s1   <= last_in;
		end
		if (adv) begin
			result_s2 <= shaped;
			last_s2   <= last_s1;
		end
	end

	nsdr_shaper u_shaper (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (adv),
		.input_is_32bit (mode_q),
		.sample         (sample_s1),
		.result         (shaped)
	);

	assign out_valid  = valid_s2;
	assign out_sample = result_s2;
	assign last_out   = last_s2;

	`NSDR_ASSERT_NEXT(a_adv_fills_result, adv, valid_s2, "item lost into result register")
	`NSDR_ASSERT_IMPL(a_stall_full, valid_s1 && !in_ready, valid_s2 && !out_ready, "early stall")
	`NSDR_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv, valid_s1 && $stable(sample_s1), "item changed")

endmodule

// ===== tb/sv/tb_noise_shaped_dither_requantizer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for noise_shaped_dither_requantizer, with a cycle-free predictor of
// the error feedback, LCG dither, clipping and 16-bit output. Depends on nsdr_pkg and the RTL.

module tb_noise_shaped_dither_requantizer;
	import nsdr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PRINT_LIMIT = 100;

	typedef struct packed {
		result_t value;
		logic    last;
	} pcm16_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic    cfg_data = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t in_sample = '0;
	logic    last_in = 1'b0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	result_t out_sample;
	logic    last_out;

	logic   shift_mode = 1'b0;
	int     fb_err_latest = 0;
	int     fb_err_prev = 0;
	int     fb_err_third = 0;
	prng_t  dither_word = '0;
	pcm16_t pending_pcm[$];
	pcm16_t want;
	int     n_fail = 0;
	int     quiet_cycles = 0;
	int     src_gap_pct = 18;
	int     sink_stall_pct = 55;

	noise_shaped_dither_requantizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_sample (in_sample),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_sample(out_sample),
		.last_out  (last_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic pcm16_t requantize_sample(input sample_t smp, input logic lst);
		longint acc;
		longint rounded;
		longint offset;
		longint quant;
		prng_t  nxt;
		pcm16_t res;
		acc = longint'(smp);
		if (shift_mode)
			acc = acc >>> 8;
		acc = acc + fb_err_latest - fb_err_prev + fb_err_third;
		fb_err_third = fb_err_prev;
		fb_err_prev = fb_err_latest / 2;
		nxt = dither_word * LCG_MUL + LCG_ADD;
		rounded = acc + longint'(ROUND_ADD) + longint'({56'd0, nxt[7:0]})
			- longint'({56'd0, dither_word[7:0]});
		dither_word = nxt;
		if (rounded > longint'(FULL_MAX)) begin
			rounded = longint'(FULL_MAX);
			if (acc > longint'(FULL_MAX))
				acc = longint'(FULL_MAX);
		end else if (rounded < longint'(FULL_MIN)) begin
			rounded = longint'(FULL_MIN);
			if (acc < longint'(FULL_MIN))
				acc = longint'(FULL_MIN);
		end
		offset = rounded - longint'(FULL_MIN);
		offset = offset - offset % 256;
		rounded = offset + longint'(FULL_MIN);
		fb_err_latest = int'(acc - rounded);
		quant = (offset >>> 8) - 32768;
		res.value = quant[15:0];
		res.last = lst;
		return res;
	endfunction

	function automatic sample_t random_pcm();
		logic [31:0] raw;
		logic [23:0] near;
		raw = $urandom();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: begin
				if (!shift_mode)
					raw = {{8{raw[23]}}, raw[23:0]};
			end
			5: begin
				near = 24'h7FFFFF - 24'($urandom_range(1023));
				raw = shift_mode ? {near, raw[7:0]} : {{8{near[23]}}, near};
			end
			6: begin
				near = 24'h800000 + 24'($urandom_range(1023));
				raw = shift_mode ? {near, raw[7:0]} : {{8{near[23]}}, near};
			end
			7: raw = 32'(int'($urandom_range(1023)) - 512);
			8: ;
			default: begin
				case ($urandom_range(3))
					0: raw = 32'h7FFFFFFF;
					1: raw = 32'h80000000;
					2: raw = 32'h00000000;
					default: raw = 32'hFFFFFFFF;
				endcase
			end
		endcase
		return sample_t'(raw);
	endfunction

	task automatic send_pcm(input sample_t smp, input logic lst);
		if ($urandom_range(99) < src_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
		end
		in_valid <= 1'b1;
		in_sample <= smp;
		last_in <= lst;
		do @(posedge clk); while (!in_ready);
		pending_pcm.push_back(requantize_sample(smp, lst));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pcm.size() != 0);
	endtask

	task automatic write_mode(input logic m);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shift_mode = m;
	endtask

	task automatic test_corners_24bit();
		sample_t corner_vals [0:11] = '{
			32'sd0, 32'sd1, -32'sd1, 32'sd8388607, -32'sd8388608, 32'sd8388480,
			-32'sd8388480, 32'h7FFFFFFF, 32'h80000000, 32'h01000000, -32'sd16777216,
			32'h00012345
		};
		write_mode(1'b0);
		for (int i = 0; i < 12; i++)
			send_pcm(corner_vals[i], (i % 4) == 3);
	endtask

	task automatic test_corners_32bit();
		sample_t corner_vals [0:9] = '{
			32'sd0, -32'sd1, 32'sd255, -32'sd256, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFF00, 32'h80000100, 32'h12345678, 32'hEDCBA988
		};
		write_mode(1'b1);
		for (int i = 0; i < 10; i++)
			send_pcm(corner_vals[i], (i % 3) == 0);
	endtask

	task automatic test_drain_pause();
		write_mode(1'b0);
		repeat (40) send_pcm(random_pcm(), $urandom_range(7) == 0);
		drain_results();
		repeat (40) send_pcm(random_pcm(), $urandom_range(7) == 0);
	endtask

	task automatic test_random_stream();
		int   src_tbl [0:5] = '{18, 18, 55, 55, 0, 0};
		int   sink_tbl [0:5] = '{55, 55, 18, 18, 0, 0};
		logic mode_tbl [0:5] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
		for (int p = 0; p < 6; p++) begin
			write_mode(mode_tbl[p]);
			src_gap_pct = src_tbl[p];
			sink_stall_pct = sink_tbl[p];
			repeat (180) send_pcm(random_pcm(), $urandom_range(7) == 0);
		end
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pcm.size() == 0) begin
				n_fail++;
				if (n_fail <= PRINT_LIMIT)
					$display("%0t: unexpected item, expected none, actual sample %0d last %0b",
						$time, out_sample, last_out);
			end else begin
				want = pending_pcm.pop_front();
				if (want.value !== out_sample) begin
					n_fail++;
					if (n_fail <= PRINT_LIMIT)
						$display("%0t: out_sample mismatch, expected %0d, actual %0d",
							$time, want.value, out_sample);
				end
				if (want.last !== last_out) begin
					n_fail++;
					if (n_fail <= PRINT_LIMIT)
						$display("%0t: last_out mismatch, expected %0b, actual %0b",
							$time, want.last, last_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("noise_shaped_dither_requantizer verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners_24bit();
		test_corners_32bit();
		test_drain_pause();
		test_random_stream();
		drain_results();
		repeat (8) @(posedge clk);
		if (n_fail == 0)
			$display("noise_shaped_dither_requantizer verification clean");
		else
			$display("noise_shaped_dither_requantizer verification failed");
		$finish;
	end

endmodule
